// ----- design/first_fit_heap_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shared assertion forms for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;
   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int HEADER_BYTES = 24;
   localparam logic [31:0] HEAP_RESET_BYTES = 32'(1024 * 1024 * 32);

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_FULL    = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef struct packed {
      logic        func;
      logic [31:0] req_bytes;
      logic [31:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [31:0] payload_addr;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic        used;
      logic [31:0] size;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_RD, S_EVAL, S_SH_RD, S_SH_WR,
      S_FR_NX, S_FR_NXD, S_FR_WR, S_RM_RD, S_RM_WR, S_RESP
   } state_type;
endpackage
`default_nettype wire

// ----- design/first_fit_heap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator with coalescing over an address-ordered block table.
// ----------------------------------------------------------------------------
// One request at a time. The block table sits in a single-port-write,
// registered-read memory; block starts are not stored but summed while
// walking. An allocate visits table entries in order and, on a split, moves
// the entries above it up by one; a free visits entries in order and, on a
// merge, moves the entries above it down. Visited and moved entries together
// never exceed the table. After reset the S_INIT state loads the initial
// free block before the first request is taken.
`default_nettype none
module first_fit_heap_allocator_unit
   import ffha_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   input  wire logic    csr_we,
   input  wire logic [31:0] csr_wdata
);
   `include "first_fit_heap_allocator_unit_defines.svh"

   entry_type mem [MAX_BLOCKS];
   entry_type rd_ff;
   logic      mem_we;
   logic [IDX_W-1:0] mem_wa, mem_ra;
   entry_type mem_wd;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, i_ff, i_in, k_ff, k_in;
   logic [1:0]  r_ff, r_in;
   logic [31:0] start_ff, start_in, nsz_ff, nsz_in;
   logic [32:0] need_ff, need_in;
   logic [33:0] need2_ff, need2_in;
   entry_type   prev_ff, prev_in;
   req_type     item_ff, item_in;
   rsp_type     rsp_ff, rsp_in;

   logic        prev_free;
   logic [CNT_W-1:0] nx_idx, rm_idx;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= csr_we ? CNT_W'(1) : cnt_in;
      end
      i_ff     <= i_in;
      k_ff     <= k_in;
      r_ff     <= r_in;
      start_ff <= start_in;
      nsz_ff   <= nsz_in;
      need_ff  <= need_in;
      need2_ff <= need2_in;
      prev_ff  <= prev_in;
      item_ff  <= item_in;
      rsp_ff   <= rsp_in;
   end

   assign prev_free = (i_ff != '0) && !prev_ff.used;
   assign nx_idx = i_ff + CNT_W'(1) + CNT_W'(r_ff);
   assign rm_idx = k_ff + CNT_W'(r_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      start_in = start_ff;
      nsz_in   = nsz_ff;
      need_in  = need_ff;
      need2_in = need2_ff;
      prev_in  = prev_ff;
      item_in  = item_ff;
      rsp_in   = rsp_ff;
      mem_we   = 1'b0;
      mem_wa   = '0;
      mem_wd   = '0;
      mem_ra   = i_ff[IDX_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            mem_we   = 1'b1;
            mem_wd   = '{used: 1'b0, size: HEAP_RESET_BYTES};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               i_in     = '0;
               start_in = '0;
               prev_in  = '{used: 1'b1, size: 32'd0};
               need_in  = {1'b0, req_payload.req_bytes} + 33'(HEADER_BYTES);
               need2_in = {2'b0, req_payload.req_bytes} + 34'(2 * HEADER_BYTES);
               if (req_payload.func == FUNC_ALLOC && req_payload.req_bytes == '0) begin
                  rsp_in   = '{payload_addr: 32'd0, status: ST_NOFIT};
                  state_in = S_RESP;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (i_ff == cnt_ff) begin
               rsp_in.payload_addr = '0;
               rsp_in.status = (item_ff.func == FUNC_ALLOC) ? ST_NOFIT : ST_IGNORED;
               state_in = S_RESP;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (item_ff.func == FUNC_ALLOC) begin
               if (rd_ff.used || {1'b0, rd_ff.size} <= need_ff) begin
                  start_in = start_ff + rd_ff.size;
                  i_in     = i_ff + CNT_W'(1);
                  state_in = S_RD;
               end else if ({2'b0, rd_ff.size} <= need2_ff) begin
                  mem_we   = 1'b1;
                  mem_wa   = i_ff[IDX_W-1:0];
                  mem_wd   = '{used: 1'b1, size: rd_ff.size};
                  rsp_in   = '{payload_addr: start_ff + 32'(HEADER_BYTES), status: ST_OK};
                  state_in = S_RESP;
               end else if (cnt_ff == CNT_W'(MAX_BLOCKS)) begin
                  rsp_in   = '{payload_addr: 32'd0, status: ST_FULL};
                  state_in = S_RESP;
               end else begin
                  mem_we   = 1'b1;
                  mem_wa   = i_ff[IDX_W-1:0];
                  mem_wd   = '{used: 1'b1, size: need_ff[31:0]};
                  nsz_in   = rd_ff.size - need_ff[31:0];
                  k_in     = cnt_ff;
                  rsp_in   = '{payload_addr: start_ff + 32'(HEADER_BYTES), status: ST_OK};
                  state_in = S_SH_RD;
               end
            end else begin
               if ({1'b0, start_ff} + 33'(HEADER_BYTES) == {1'b0, item_ff.free_addr}) begin
                  if (!rd_ff.used) begin
                     rsp_in   = '{payload_addr: 32'd0, status: ST_IGNORED};
                     state_in = S_RESP;
                  end else begin
                     // fold a free predecessor in; i becomes its index
                     nsz_in   = rd_ff.size + (prev_free ? prev_ff.size : 32'd0);
                     r_in     = prev_free ? 2'd1 : 2'd0;
                     i_in     = prev_free ? i_ff - CNT_W'(1) : i_ff;
                     rsp_in   = '{payload_addr: 32'd0, status: ST_OK};
                     state_in = S_FR_NX;
                  end
               end else begin
                  prev_in  = rd_ff;
                  start_in = start_ff + rd_ff.size;
                  i_in     = i_ff + CNT_W'(1);
                  state_in = S_RD;
               end
            end
         end
         S_SH_RD: begin
            mem_ra = IDX_W'(k_ff - CNT_W'(1));
            if (k_ff == i_ff + CNT_W'(1)) begin
               mem_we   = 1'b1;
               mem_wa   = k_ff[IDX_W-1:0];
               mem_wd   = '{used: 1'b0, size: nsz_ff};
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = S_RESP;
            end else begin
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            mem_we   = 1'b1;
            mem_wa   = k_ff[IDX_W-1:0];
            mem_wd   = rd_ff;
            k_in     = k_ff - CNT_W'(1);
            state_in = S_SH_RD;
         end
         S_FR_NX: begin
            mem_ra = nx_idx[IDX_W-1:0];
            state_in = (nx_idx < cnt_ff) ? S_FR_NXD : S_FR_WR;
         end
         S_FR_NXD: begin
            if (!rd_ff.used) begin
               nsz_in = nsz_ff + rd_ff.size;
               r_in   = r_ff + 2'd1;
            end
            state_in = S_FR_WR;
         end
         S_FR_WR: begin
            mem_we   = 1'b1;
            mem_wa   = i_ff[IDX_W-1:0];
            mem_wd   = '{used: 1'b0, size: nsz_ff};
            k_in     = i_ff + CNT_W'(1);
            state_in = (r_ff == 2'd0) ? S_RESP : S_RM_RD;
         end
         S_RM_RD: begin
            mem_ra = rm_idx[IDX_W-1:0];
            if (rm_idx >= cnt_ff) begin
               cnt_in   = cnt_ff - CNT_W'(r_ff);
               state_in = S_RESP;
            end else begin
               state_in = S_RM_WR;
            end
         end
         S_RM_WR: begin
            mem_we   = 1'b1;
            mem_wa   = k_ff[IDX_W-1:0];
            mem_wd   = rd_ff;
            k_in     = k_ff + CNT_W'(1);
            state_in = S_RM_RD;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // heap size write reloads entry zero; the user must write it only while idle, the block does not enforce this
      if (csr_we) begin
         mem_we = 1'b1;
         mem_wa = '0;
         mem_wd = '{used: 1'b0, size: csr_wdata};
      end
   end

   `FFHA_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, (cnt_ff != '0) && (cnt_ff <= CNT_W'(MAX_BLOCKS)), "block count out of range")
   `FFHA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && (rsp_payload.status != ST_OK), rsp_payload.payload_addr == '0, "failed result carries an address")
   `FFHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")
endmodule
`default_nettype wire
